@@ hdl/sib_pkg.sv @@
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types, codes and helpers for the static IMU bias initialiser.
// ----------------------------------------------------------------------------
package sib_pkg;

  localparam int AXES   = 6;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // item kinds
  localparam logic OP_IMU  = 1'b0;
  localparam logic OP_ODOM = 1'b1;

  // result status codes
  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_WAIT_STILL  = 3'd1;
  localparam logic [2:0] ST_COLLECT     = 3'd2;
  localparam logic [2:0] ST_TOO_FEW     = 3'd3;
  localparam logic [2:0] ST_GYRO_NOISY  = 3'd4;
  localparam logic [2:0] ST_ACCEL_NOISY = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_USE_STATIC = 3'd0;
  localparam logic [2:0] REG_STILL_LIM  = 3'd1;
  localparam logic [2:0] REG_SETTLE     = 3'd2;
  localparam logic [2:0] REG_GRAVITY    = 3'd3;
  localparam logic [2:0] REG_MAX_GYRO   = 3'd4;
  localparam logic [2:0] REG_MAX_ACCEL  = 3'd5;

  localparam int GYRO_SHIFT  = 8;
  localparam int ACCEL_SHIFT = 16;
  localparam logic [63:0] SUM_CAP = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic              use_static_check;
    logic [15:0]       still_pulse_limit;
    logic [31:0]       settle_time;
    logic [31:0]       gravity_magnitude;
    logic [47:0]       max_gyro_variance;
    logic [47:0]       max_accel_variance;
  } cfg_t;

  // axis[0..2] gyro x/y/z, axis[3..5] accel x/y/z
  typedef struct packed {
    logic              op;
    logic              still;
    logic [47:0]       timestamp;
    logic [5:0][31:0]  axis;
  } item_t;

  // value[0..2] gyro bias, [3..5] accel bias, [6..8] gravity
  typedef struct packed {
    logic              initialized;
    logic [2:0]        status;
    logic [8:0][31:0]  value;
  } result_t;

  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    logic [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/sib_ram.sv @@
// ----------------------------------------------------------------------------
// sib_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sib_ram #(
  parameter int WIDTH = 192,
  parameter int DEPTH = 2049,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sib_div.sv @@
// ----------------------------------------------------------------------------
// sib_div
// Restoring 64 by 64 bit unsigned divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sib_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [65:0] trial;

  assign trial    = {1'b0, rem, quo[63]} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[65]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/sib_front.sv @@
// ----------------------------------------------------------------------------
// sib_front
// Input side: accept items, tag their kind and stillness, hold them in a
// two word queue for the engine.
// ----------------------------------------------------------------------------
module sib_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            kind,
  input  logic [47:0]     timestamp,
  input  logic [5:0][31:0] axis,
  input  logic [15:0]     left_pulse,
  input  logic [15:0]     right_pulse,
  input  logic [15:0]     still_pulse_limit,
  output logic            item_valid,
  output sib_pkg::item_t  item,
  input  logic            item_take
);

  sib_pkg::item_t slot [2];
  sib_pkg::item_t tagged_item;
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           accept;

  assign full       = (cnt == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (cnt != 2'd0);
  assign item       = slot[rp];

  always_comb begin
    tagged_item.op        = kind ? sib_pkg::OP_ODOM : sib_pkg::OP_IMU;
    tagged_item.still     = (left_pulse < still_pulse_limit) &&
                            (right_pulse < still_pulse_limit);
    tagged_item.timestamp = timestamp;
    tagged_item.axis      = axis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (accept) begin
        wp <= ~wp;
      end
      if (item_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, item_take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wp] <= tagged_item;
    end
  end

endmodule

@@ hdl/sib_back.sv @@
// ----------------------------------------------------------------------------
// sib_back
// Engine: keeps the sample window, runs the mean, gravity and variance
// passes, latches biases and queues one result word per item.
// ----------------------------------------------------------------------------
module sib_back #(
  parameter int WINDOW_DEPTH = 2048,
  parameter int MIN_SAMPLES  = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  sib_pkg::cfg_t     cfg,
  input  logic              item_valid,
  input  sib_pkg::item_t    item,
  output logic              item_take,
  output logic              res_valid,
  output sib_pkg::result_t  res,
  input  logic              res_pop
);

  localparam int SLOTS = WINDOW_DEPTH + 1;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(WINDOW_DEPTH + 2);
  localparam int SW    = 32 + CW;
  localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
  localparam logic [CW-1:0] MIN_C     = CW'(MIN_SAMPLES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [AW:0]   SLOTS_C   = (AW + 1)'(SLOTS);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLASS   = 5'd1;
  localparam logic [4:0] S_ATTEMPT = 5'd2;
  localparam logic [4:0] S_SUM     = 5'd3;
  localparam logic [4:0] S_MDIV    = 5'd4;
  localparam logic [4:0] S_MWAIT   = 5'd5;
  localparam logic [4:0] S_NSQ     = 5'd6;
  localparam logic [4:0] S_RINIT   = 5'd7;
  localparam logic [4:0] S_ROOT    = 5'd8;
  localparam logic [4:0] S_GRAV    = 5'd9;
  localparam logic [4:0] S_GMUL    = 5'd10;
  localparam logic [4:0] S_GDIV    = 5'd11;
  localparam logic [4:0] S_GWAIT   = 5'd12;
  localparam logic [4:0] S_VINIT   = 5'd13;
  localparam logic [4:0] S_VAR     = 5'd14;
  localparam logic [4:0] S_VDIV    = 5'd15;
  localparam logic [4:0] S_VWAIT   = 5'd16;
  localparam logic [4:0] S_NZ      = 5'd17;
  localparam logic [4:0] S_NCMP    = 5'd18;
  localparam logic [4:0] S_MAC     = 5'd19;
  localparam logic [4:0] S_TRIM    = 5'd20;
  localparam logic [4:0] S_OUT     = 5'd21;

  logic [4:0]          state;
  logic [4:0]          ret_state;
  sib_pkg::item_t      cur;
  logic                still;
  logic                done;
  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [47:0]         start_time;
  logic [2:0]          status;
  logic signed [31:0]  gbias [3];
  logic signed [31:0]  abias [3];
  logic signed [31:0]  grav [3];
  logic signed [31:0]  mean [6];
  logic signed [SW-1:0] sum [6];
  logic [63:0]         sq [6];
  logic [63:0]         vari [6];
  logic [31:0]         dmag [6];
  logic [63:0]         prod [6];
  logic [AW-1:0]       rp;
  logic [CW-1:0]       k;
  logic                v1, v2, v3;
  logic [2:0]          mi;
  logic [1:0]          ax;
  logic                grp;
  logic [63:0]         mac_a, mac_b, mprod;
  logic [2:0]          pp;
  logic [127:0]        acc, hold;
  logic [63:0]         sq_v, sq_r, sq_bit;
  logic [31:0]         norm;

  // divider
  logic        div_start;
  logic [63:0] div_a, div_b, div_q;
  logic        div_done;

  // RAM
  logic          ram_we;
  logic [AW-1:0] wr_addr;
  logic [AW:0]   wsum;
  logic [191:0]  ram_rdata;

  // output queue
  sib_pkg::result_t oq [2];
  sib_pkg::result_t new_res;
  logic             owp, orp;
  logic [1:0]       ocnt;
  logic             opush;

  // helpers
  logic                blocked;
  logic [47:0]         start_eff;
  logic [47:0]         elapsed;
  logic signed [SW-1:0] sum_sel;
  logic [SW-1:0]       sum_mag;
  logic signed [31:0]  mean_sel;
  logic [31:0]         mean_mag;
  logic [2:0]          vidx;
  logic [63:0]         var_sel;
  logic [63:0]         limit_sel;
  logic [31:0]         mac_ah, mac_bh;
  logic [127:0]        mprod_sh;
  logic [63:0]         root_try;
  logic [AW-1:0]       rp_next;
  logic [AW-1:0]       head_next;
  logic                issue;
  logic [1:0]          gidx;

  sib_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  sib_ram #(.WIDTH(192), .DEPTH(SLOTS)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (cur.axis),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  always_comb begin
    blocked   = cfg.use_static_check && !still;
    wsum      = {1'b0, head} + (AW + 1)'(count);
    wr_addr   = (wsum >= SLOTS_C) ? AW'(wsum - SLOTS_C) : wsum[AW-1:0];
    ram_we    = (state == S_CLASS) && !done && (cur.op == sib_pkg::OP_IMU) && !blocked;
    start_eff = (count == '0) ? cur.timestamp : start_time;
    elapsed   = (cur.timestamp >= start_eff) ? cur.timestamp - start_eff : '0;
    sum_sel   = sum[mi];
    sum_mag   = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
    mean_sel  = mean[mi];
    mean_mag  = mean_sel[31] ? 32'(-mean_sel) : 32'(mean_sel);
    vidx      = grp ? 3'(ax) + 3'd3 : 3'(ax);
    var_sel   = vari[vidx];
    limit_sel = grp ? 64'(cfg.max_accel_variance) : 64'(cfg.max_gyro_variance);
    mac_ah    = pp[2] ? mac_a[63:32] : mac_a[31:0];
    mac_bh    = pp[1] ? mac_b[63:32] : mac_b[31:0];
    case ({pp[2], pp[1]})
      2'b00:   mprod_sh = 128'(mprod);
      2'b11:   mprod_sh = 128'(mprod) << 64;
      default: mprod_sh = 128'(mprod) << 32;
    endcase
    root_try  = sq_r + sq_bit;
    rp_next   = (rp == LAST_SLOT) ? '0 : rp + AW'(1);
    head_next = (head == LAST_SLOT) ? '0 : head + AW'(1);
    issue     = (k != count);
    gidx      = 2'(mi - 3'd3);
    opush     = (state == S_OUT);
    item_take = (state == S_IDLE) && item_valid && (ocnt != 2'd2);
    new_res.initialized = done;
    new_res.status      = status;
    for (int a = 0; a < 3; a++) begin
      new_res.value[a]     = gbias[a];
      new_res.value[3 + a] = abias[a];
      new_res.value[6 + a] = grav[a];
    end
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      still      <= 1'b0;
      done       <= 1'b0;
      head       <= '0;
      count      <= '0;
      start_time <= '0;
      div_start  <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        gbias[a] <= '0;
        abias[a] <= '0;
        grav[a]  <= '0;
      end
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            cur   <= item;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (done) begin
            status <= sib_pkg::ST_DONE;
            state  <= S_OUT;
          end else if (cur.op == sib_pkg::OP_ODOM) begin
            still  <= cur.still;
            status <= (cfg.use_static_check && !cur.still) ? sib_pkg::ST_WAIT_STILL
                                                           : sib_pkg::ST_COLLECT;
            state  <= S_OUT;
          end else if (blocked) begin
            count  <= '0;
            head   <= '0;
            status <= sib_pkg::ST_WAIT_STILL;
            state  <= S_OUT;
          end else begin
            if (count == '0) begin
              start_time <= cur.timestamp;
            end
            count <= count + CW'(1);
            if (elapsed > 48'(cfg.settle_time)) begin
              state <= S_ATTEMPT;
            end else begin
              status <= sib_pkg::ST_COLLECT;
              state  <= S_TRIM;
            end
          end
        end
        S_ATTEMPT: begin
          if (count < MIN_C) begin
            status <= sib_pkg::ST_TOO_FEW;
            state  <= S_TRIM;
          end else begin
            rp <= head;
            k  <= '0;
            v1 <= 1'b0;
            for (int a = 0; a < 6; a++) begin
              sum[a] <= '0;
            end
            state <= S_SUM;
          end
        end
        S_SUM: begin
          v1 <= issue;
          if (issue) begin
            rp <= rp_next;
            k  <= k + CW'(1);
          end
          if (v1) begin
            for (int a = 0; a < 6; a++) begin
              sum[a] <= sum[a] + SW'(signed'(ram_rdata[a*32 +: 32]));
            end
          end
          if (!issue && !v1) begin
            mi    <= '0;
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          div_start <= 1'b1;
          div_a     <= 64'(sum_mag) + 64'(count >> 1);
          div_b     <= 64'(count);
          state     <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_done) begin
            mean[mi] <= sum_sel[SW-1] ? -signed'(div_q[31:0]) : signed'(div_q[31:0]);
            if (mi == 3'd5) begin
              mi    <= 3'd3;
              acc   <= '0;
              state <= S_NSQ;
            end else begin
              mi    <= mi + 3'd1;
              state <= S_MDIV;
            end
          end
        end
        S_NSQ: begin
          mac_a     <= 64'(mean_mag);
          mac_b     <= 64'(mean_mag);
          pp        <= '0;
          ret_state <= (mi == 3'd5) ? S_RINIT : S_NSQ;
          mi        <= mi + 3'd1;
          state     <= S_MAC;
        end
        S_RINIT: begin
          sq_v   <= acc[63:0];
          sq_r   <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          state  <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_v >= root_try) begin
            sq_v <= sq_v - root_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == 64'd1) begin
            norm  <= (sq_v >= root_try) ? 32'((sq_r >> 1) + sq_bit) : 32'(sq_r >> 1);
            state <= S_GRAV;
          end
        end
        S_GRAV: begin
          if (norm == '0) begin
            for (int a = 0; a < 3; a++) begin
              grav[a] <= '0;
            end
            state <= S_VINIT;
          end else begin
            mi    <= 3'd3;
            state <= S_GMUL;
          end
        end
        S_GMUL: begin
          acc       <= '0;
          mac_a     <= 64'(mean_mag);
          mac_b     <= 64'(cfg.gravity_magnitude);
          pp        <= '0;
          ret_state <= S_GDIV;
          state     <= S_MAC;
        end
        S_GDIV: begin
          div_start <= 1'b1;
          div_a     <= acc[63:0] + 64'(norm >> 1);
          div_b     <= 64'(norm);
          state     <= S_GWAIT;
        end
        S_GWAIT: begin
          if (div_done) begin
            // gravity points against the mean specific force
            grav[gidx] <= mean_sel[31] ? sib_pkg::sat32(signed'({1'b0, div_q}))
                                       : sib_pkg::sat32(-signed'({1'b0, div_q}));
            if (mi == 3'd5) begin
              state <= S_VINIT;
            end else begin
              mi    <= mi + 3'd1;
              state <= S_GMUL;
            end
          end
        end
        S_VINIT: begin
          rp <= head;
          k  <= '0;
          v1 <= 1'b0;
          v2 <= 1'b0;
          v3 <= 1'b0;
          for (int a = 0; a < 6; a++) begin
            sq[a] <= '0;
          end
          state <= S_VAR;
        end
        S_VAR: begin
          v1 <= issue;
          v2 <= v1;
          v3 <= v2;
          if (issue) begin
            rp <= rp_next;
            k  <= k + CW'(1);
          end
          for (int a = 0; a < 6; a++) begin
            logic signed [32:0] d;
            logic [32:0]        m;
            logic [63:0]        t;
            d = 33'(signed'(ram_rdata[a*32 +: 32])) - 33'(mean[a]);
            m = d[32] ? 33'(-d) : 33'(d);
            t = sq[a] + (prod[a] >> ((a < 3) ? sib_pkg::GYRO_SHIFT : sib_pkg::ACCEL_SHIFT));
            if (v1) begin
              dmag[a] <= m[32] ? 32'hffff_ffff : m[31:0];
            end
            if (v2) begin
              prod[a] <= dmag[a] * dmag[a];
            end
            if (v3) begin
              sq[a] <= (t > sib_pkg::SUM_CAP) ? sib_pkg::SUM_CAP : t;
            end
          end
          if (!issue && !v1 && !v2 && !v3) begin
            mi    <= '0;
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          div_start <= 1'b1;
          div_a     <= sq[mi];
          div_b     <= 64'(count - CW'(1));
          state     <= S_VWAIT;
        end
        S_VWAIT: begin
          if (div_done) begin
            vari[mi] <= div_q;
            if (mi == 3'd5) begin
              grp   <= 1'b0;
              ax    <= '0;
              acc   <= '0;
              state <= S_NZ;
            end else begin
              mi    <= mi + 3'd1;
              state <= S_VDIV;
            end
          end
        end
        S_NZ: begin
          pp <= '0;
          if (ax != 2'd3) begin
            mac_a     <= var_sel;
            mac_b     <= var_sel;
            ax        <= ax + 2'd1;
            ret_state <= S_NZ;
          end else begin
            hold      <= acc;
            acc       <= '0;
            mac_a     <= limit_sel;
            mac_b     <= limit_sel;
            ret_state <= S_NCMP;
          end
          state <= S_MAC;
        end
        S_NCMP: begin
          if (hold > acc) begin
            status <= grp ? sib_pkg::ST_ACCEL_NOISY : sib_pkg::ST_GYRO_NOISY;
            state  <= S_TRIM;
          end else if (!grp) begin
            grp   <= 1'b1;
            ax    <= '0;
            acc   <= '0;
            state <= S_NZ;
          end else begin
            for (int a = 0; a < 3; a++) begin
              gbias[a] <= mean[a];
              abias[a] <= sib_pkg::sat32(65'(mean[3 + a]) + 65'(grav[a]));
            end
            done   <= 1'b1;
            status <= sib_pkg::ST_DONE;
            state  <= S_TRIM;
          end
        end
        S_MAC: begin
          // four 32x32 partial products, multiply then accumulate
          if (!pp[0]) begin
            mprod <= mac_ah * mac_bh;
          end else begin
            acc <= acc + mprod_sh;
          end
          pp <= pp + 3'd1;
          if (pp == 3'd7) begin
            state <= ret_state;
          end
        end
        S_TRIM: begin
          if (count > DEPTH_C) begin
            head  <= head_next;
            count <= count - CW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result queue
  assign res_valid = (ocnt != 2'd0);
  assign res       = oq[orp];

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (opush) begin
        owp <= ~owp;
      end
      if (res_pop && res_valid) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + {1'b0, opush} - {1'b0, res_pop && res_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      oq[owp] <= new_res;
    end
  end

endmodule

@@ hdl/static_imu_bias_init.sv @@
// ----------------------------------------------------------------------------
// static_imu_bias_init
// Initial IMU bias and gravity estimate from a still vehicle.
// ----------------------------------------------------------------------------
// Input queue: assert push with an item while full is low. kind selects an
// IMU sample (gyro/accel fields) or a wheel odometry reading (pulse fields).
// Result queue: one word per item, readable while empty is low; pop takes it.
// Configuration: APB-style, 64-bit data, register i at byte address 8*i;
// write only while the block is idle.
// An attempt walks the window twice through the single RAM read port and
// runs 15 divisions on the bit-serial divider. One item is worked on at a
// time; a two-word queue in front takes the next item.
// Reset: window empty, vehicle taken as moving, biases and gravity zero,
// registers at their defaults; no clearing pass is needed.
// A stalled receiver fills the two-word result queue, the engine then holds
// before its next item and full rises once the input queue is full too.
// ----------------------------------------------------------------------------
module static_imu_bias_init #(
  parameter int WINDOW_DEPTH = 2048,
  parameter int MIN_SAMPLES  = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [47:0] timestamp,
  input  logic signed [31:0] gyro_x,
  input  logic signed [31:0] gyro_y,
  input  logic signed [31:0] gyro_z,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic [15:0] left_pulse,
  input  logic [15:0] right_pulse,
  output logic        empty,
  input  logic        pop,
  output logic        initialized,
  output logic [2:0]  status,
  output logic signed [31:0] gyro_bias_x,
  output logic signed [31:0] gyro_bias_y,
  output logic signed [31:0] gyro_bias_z,
  output logic signed [31:0] accel_bias_x,
  output logic signed [31:0] accel_bias_y,
  output logic signed [31:0] accel_bias_z,
  output logic signed [31:0] gravity_x,
  output logic signed [31:0] gravity_y,
  output logic signed [31:0] gravity_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [sib_pkg::ADDR_W-1:0] paddr,
  input  logic [sib_pkg::DATA_W-1:0] pwdata,
  output logic [sib_pkg::DATA_W-1:0] prdata,
  output logic        pready
);

  sib_pkg::cfg_t    cfg;
  sib_pkg::item_t   item;
  sib_pkg::result_t res;
  logic             item_valid;
  logic             item_take;
  logic             res_valid;
  logic             cfg_we;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  // configuration registers; writes past the list drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_static_check   <= 1'b1;
      cfg.still_pulse_limit  <= 16'd5;
      cfg.settle_time        <= 32'd10000000;
      cfg.gravity_magnitude  <= 32'd164584489;
      cfg.max_gyro_variance  <= 48'd2147483648;
      cfg.max_accel_variance <= 48'd214748365;
    end else if (cfg_we) begin
      unique case (reg_idx)
        sib_pkg::REG_USE_STATIC: cfg.use_static_check   <= pwdata[0];
        sib_pkg::REG_STILL_LIM:  cfg.still_pulse_limit  <= pwdata[15:0];
        sib_pkg::REG_SETTLE:     cfg.settle_time        <= pwdata[31:0];
        sib_pkg::REG_GRAVITY:    cfg.gravity_magnitude  <= pwdata[31:0];
        sib_pkg::REG_MAX_GYRO:   cfg.max_gyro_variance  <= pwdata[47:0];
        sib_pkg::REG_MAX_ACCEL:  cfg.max_accel_variance <= pwdata[47:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      sib_pkg::REG_USE_STATIC: prdata = 64'(cfg.use_static_check);
      sib_pkg::REG_STILL_LIM:  prdata = 64'(cfg.still_pulse_limit);
      sib_pkg::REG_SETTLE:     prdata = 64'(cfg.settle_time);
      sib_pkg::REG_GRAVITY:    prdata = 64'(cfg.gravity_magnitude);
      sib_pkg::REG_MAX_GYRO:   prdata = 64'(cfg.max_gyro_variance);
      sib_pkg::REG_MAX_ACCEL:  prdata = 64'(cfg.max_accel_variance);
      default:                 prdata = '0;
    endcase
  end

  // front: accept and tag items
  sib_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .kind              (kind),
    .timestamp         (timestamp),
    .axis              ({accel_z, accel_y, accel_x, gyro_z, gyro_y, gyro_x}),
    .left_pulse        (left_pulse),
    .right_pulse       (right_pulse),
    .still_pulse_limit (cfg.still_pulse_limit),
    .item_valid        (item_valid),
    .item              (item),
    .item_take         (item_take)
  );

  // back: window, statistics and result queue
  sib_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_SAMPLES  (MIN_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  // hand the oldest result word to the ports
  assign empty        = !res_valid;
  assign initialized  = res.initialized;
  assign status       = res.status;
  assign gyro_bias_x  = res.value[0];
  assign gyro_bias_y  = res.value[1];
  assign gyro_bias_z  = res.value[2];
  assign accel_bias_x = res.value[3];
  assign accel_bias_y = res.value[4];
  assign accel_bias_z = res.value[5];
  assign gravity_x    = res.value[6];
  assign gravity_y    = res.value[7];
  assign gravity_z    = res.value[8];

endmodule

@@ bench/static_imu_bias_init_tb.sv @@
// ----------------------------------------------------------------------------
// static_imu_bias_init_tb
// Self-checking bench for the static IMU bias and gravity initialiser.
// ----------------------------------------------------------------------------
// A directed table of words opens the run: reset results, odometry gating,
// dropped samples, timestamp wrap-back, too few samples, noisy windows and
// zero mean acceleration. Random phases follow, each a random odometry word,
// a random sample and a well-formed still window, with registers rewritten
// between phases while the block is idle. Every result word is checked
// against a predictor kept in the bench. Sender and receiver idle at random;
// one phase stalls the receiver long enough for the block to fill and hold
// full.
// ----------------------------------------------------------------------------
module static_imu_bias_init_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 2048;
  localparam int MIN_SAMP  = 10;
  localparam int SLOTS     = WIN_DEPTH + 1;
  localparam int LIMIT_CYC = 2000000;
  localparam int SETTLE_GAP = 6000;
  localparam int EXP_DEPTH = 256;
  localparam int ROW_DEPTH = 32;

  typedef struct {
    logic              kind;
    logic [47:0]       ts;
    logic signed [31:0] ax[6];
    logic [15:0]       lp;
    logic [15:0]       rp;
  } imu_word_t;

  typedef struct {
    logic              init;
    logic [2:0]        st;
    logic [31:0]       val[9];
  } bias_word_t;

  typedef struct {
    imu_word_t  w;
    bit         typed;
    logic [2:0] st;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic kind = 1'b0;
  logic [47:0] timestamp = '0;
  logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
  logic signed [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic [15:0] left_pulse = '0, right_pulse = '0;
  logic empty;
  logic pop = 1'b0;
  logic initialized;
  logic [2:0] status;
  logic signed [31:0] gyro_bias_x, gyro_bias_y, gyro_bias_z;
  logic signed [31:0] accel_bias_x, accel_bias_y, accel_bias_z;
  logic signed [31:0] gravity_x, gravity_y, gravity_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [sib_pkg::ADDR_W-1:0] paddr = '0;
  logic [sib_pkg::DATA_W-1:0] pwdata = '0;
  logic [sib_pkg::DATA_W-1:0] prdata;
  logic pready;

  static_imu_bias_init dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [31:0] win_mem[SLOTS][6];
  int unsigned win_cnt, win_hd;
  logic [47:0] win_t0;
  bit still_now, done_now;
  logic signed [31:0] bg_now[9];
  logic use_chk;
  logic [15:0] still_lim;
  logic [31:0] settle_us, grav_mag;
  logic [47:0] gyro_lim, accel_lim;

  // expected words, oldest at exp_rd
  bias_word_t exp_mem[EXP_DEPTH];
  int exp_wr = 0, exp_rd = 0;
  dir_row_t rows[ROW_DEPTH];
  int n_rows = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle = 0, recv_idle = 0;
  bit recv_hold = 1'b0;
  int hold_cycles = 0;

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic longint round_q(longint s, longint n);
    longint m;
    m = (s < 0) ? -s : s;
    m = (m + n / 2) / n;
    return (s < 0) ? -m : m;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic bit too_noisy(int base, longint mn[6], int sh, logic [47:0] lim);
    logic [127:0] acc;
    logic [63:0] sum, m, v;
    longint d;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      sum = 0;
      for (int k = 0; k < win_cnt; k++) begin
        d = longint'(win_mem[(win_hd + k) % SLOTS][base + a]) - mn[base + a];
        m = (d < 0) ? -d : d;
        if (m > 64'hffff_ffff) m = 64'hffff_ffff;
        sum = sum + ((m * m) >> sh);
        if (sum > sib_pkg::SUM_CAP) sum = sib_pkg::SUM_CAP;
      end
      v = sum / (win_cnt - 1);
      acc = acc + 128'(v) * 128'(v);
    end
    return acc > 128'(lim) * 128'(lim);
  endfunction

  function automatic logic [2:0] try_latch();
    longint mn[6], s, gr[3];
    logic [63:0] nsq, nrm, mag, q;
    if (win_cnt < MIN_SAMP) return sib_pkg::ST_TOO_FEW;
    for (int a = 0; a < 6; a++) begin
      s = 0;
      for (int k = 0; k < win_cnt; k++) s += win_mem[(win_hd + k) % SLOTS][a];
      mn[a] = round_q(s, win_cnt);
    end
    nsq = 0;
    for (int a = 3; a < 6; a++) nsq = nsq + 64'(mn[a] * mn[a]);
    nrm = root64(nsq);
    for (int a = 0; a < 3; a++) begin
      if (nrm == 0) begin
        gr[a] = 0;
      end else begin
        mag = (mn[3 + a] < 0) ? -mn[3 + a] : mn[3 + a];
        q = (mag * grav_mag + nrm / 2) / nrm;
        gr[a] = longint'($signed(clip32((mn[3 + a] < 0) ? longint'(q) : -longint'(q))));
      end
      bg_now[6 + a] = gr[a][31:0];
    end
    if (too_noisy(0, mn, sib_pkg::GYRO_SHIFT, gyro_lim)) return sib_pkg::ST_GYRO_NOISY;
    if (too_noisy(3, mn, sib_pkg::ACCEL_SHIFT, accel_lim)) return sib_pkg::ST_ACCEL_NOISY;
    for (int a = 0; a < 3; a++) begin
      bg_now[a] = mn[a][31:0];
      bg_now[3 + a] = clip32(mn[3 + a] + gr[a]);
    end
    done_now = 1'b1;
    return sib_pkg::ST_DONE;
  endfunction

  function automatic bias_word_t predict_bias(imu_word_t w);
    bias_word_t r;
    logic [2:0] st;
    logic [47:0] el;
    int idx;
    st = sib_pkg::ST_DONE;
    if (!done_now) begin
      if (w.kind == sib_pkg::OP_ODOM) begin
        still_now = (w.lp < still_lim) && (w.rp < still_lim);
        st = (use_chk && !still_now) ? sib_pkg::ST_WAIT_STILL : sib_pkg::ST_COLLECT;
      end else if (use_chk && !still_now) begin
        win_cnt = 0;
        win_hd = 0;
        st = sib_pkg::ST_WAIT_STILL;
      end else begin
        if (win_cnt == 0) win_t0 = w.ts;
        if (win_cnt >= SLOTS) begin
          win_hd = (win_hd + 1) % SLOTS;
          win_cnt--;
        end
        idx = (win_hd + win_cnt) % SLOTS;
        for (int a = 0; a < 6; a++) win_mem[idx][a] = w.ax[a];
        win_cnt++;
        el = (w.ts >= win_t0) ? w.ts - win_t0 : 48'd0;
        st = (el > settle_us) ? try_latch() : sib_pkg::ST_COLLECT;
        while (win_cnt > WIN_DEPTH) begin
          win_hd = (win_hd + 1) % SLOTS;
          win_cnt--;
        end
      end
    end
    r.init = done_now;
    r.st = st;
    for (int a = 0; a < 9; a++) r.val[a] = bg_now[a];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------
  // Send one word; the expectation is queued when the block takes it.
  // push stays high afterwards so that words can follow back to back.
  task automatic send_word(imu_word_t w);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    push <= 1'b1;
    kind <= w.kind;
    timestamp <= w.ts;
    gyro_x <= w.ax[0];
    gyro_y <= w.ax[1];
    gyro_z <= w.ax[2];
    accel_x <= w.ax[3];
    accel_y <= w.ax[4];
    accel_z <= w.ax[5];
    left_pulse <= w.lp;
    right_pulse <= w.rp;
    do @(posedge clk); while (full);
    exp_mem[exp_wr % EXP_DEPTH] = predict_bias(w);
    exp_wr++;
  endtask

  // Writes may follow back to back: the next setup comes straight after access.
  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= sib_pkg::ADDR_W'(idx) << 3;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    case (idx)
      sib_pkg::REG_USE_STATIC: use_chk = v[0];
      sib_pkg::REG_STILL_LIM:  still_lim = v[15:0];
      sib_pkg::REG_SETTLE:     settle_us = v[31:0];
      sib_pkg::REG_GRAVITY:    grav_mag = v[31:0];
      sib_pkg::REG_MAX_GYRO:   gyro_lim = v[47:0];
      default:                 accel_lim = v[47:0];
    endcase
  endtask

  // Release the bus after a run of writes.
  task automatic bus_idle();
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drain, then let any in-flight attempt finish before touching registers.
  task automatic wait_idle();
    push <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic add_row(imu_word_t w, bit typed, logic [2:0] st);
    rows[n_rows] = '{w, typed, st};
    n_rows++;
  endtask

  // ------------------------------------------------------------------------
  // receiver and checker
  // ------------------------------------------------------------------------
  task automatic check_word();
    bias_word_t e;
    logic [31:0] got[9];
    bit bad;
    got = '{gyro_bias_x, gyro_bias_y, gyro_bias_z, accel_bias_x, accel_bias_y,
            accel_bias_z, gravity_x, gravity_y, gravity_z};
    if (exp_wr == exp_rd) begin
      errors++;
      if (errors <= 10) $display("unexpected word: status %0d", status);
    end else begin
      e = exp_mem[exp_rd % EXP_DEPTH];
      exp_rd++;
      bad = (e.init !== initialized) || (e.st !== status);
      for (int a = 0; a < 9; a++) if (e.val[a] !== got[a]) bad = 1'b1;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: init %0b/%0b status %0d/%0d", e.init, initialized,
                   e.st, status);
          for (int a = 0; a < 9; a++)
            $display("  value[%0d] expected %h got %h", a, e.val[a], got[a]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (recv_hold && hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      if (pop && !empty) begin
        check_word();
      end
      pop <= !(recv_hold && hold_cycles > 0) &&
             !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  function automatic imu_word_t odom(int l, int r);
    imu_word_t w;
    w.kind = sib_pkg::OP_ODOM;
    w.ts = 48'({$urandom, $urandom});
    for (int a = 0; a < 6; a++) w.ax[a] = $urandom;
    w.lp = l[15:0];
    w.rp = r[15:0];
    return w;
  endfunction

  function automatic imu_word_t imu(logic [47:0] t, int g, int ac, int noise);
    imu_word_t w;
    w.kind = sib_pkg::OP_IMU;
    w.ts = t;
    for (int a = 0; a < 3; a++) w.ax[a] = g + $urandom_range(noise) - noise / 2;
    for (int a = 3; a < 6; a++) w.ax[a] = ac * (a == 5 ? 16 : 1)
                                          + $urandom_range(noise) - noise / 2;
    w.lp = 16'($urandom);
    w.rp = 16'($urandom);
    return w;
  endfunction

  // One still window: odometry still, then samples spanning the settle time.
  task automatic still_window(int n, int noise);
    logic [47:0] t;
    int g, ac;
    t = 48'({$urandom, $urandom} >> 2);
    g = $urandom_range(4000) - 2000;
    ac = $urandom_range(2000000) - 1000000;
    send_word(odom(0, 0));
    for (int i = 0; i < n; i++) begin
      send_word(imu(t, g, ac, noise));
      t = t + 48'(settle_us / (n - 2)) + 48'd1;
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    imu_word_t w;
    int p;
    win_cnt = 0; win_hd = 0; win_t0 = 0;
    still_now = 0; done_now = 0;
    for (int a = 0; a < 9; a++) bg_now[a] = 0;
    use_chk = 1; still_lim = 5; settle_us = 10000000; grav_mag = 164584489;
    gyro_lim = 48'd2147483648; accel_lim = 48'd214748365;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short settle so a window fits into few words
    reg_write(sib_pkg::REG_SETTLE, 64'd100);
    reg_write(sib_pkg::REG_MAX_GYRO, 64'hffff_ffff_ffff);
    reg_write(sib_pkg::REG_MAX_ACCEL, 64'hffff_ffff_ffff);
    bus_idle();
    w = imu(48'd5, 0, 0, 0);
    add_row(w, 1, sib_pkg::ST_WAIT_STILL);          // moving at reset: drop
    add_row(odom(16'hffff, 0), 1, sib_pkg::ST_WAIT_STILL);
    add_row(odom(4, 4), 1, sib_pkg::ST_COLLECT);
    add_row(odom(5, 0), 1, sib_pkg::ST_WAIT_STILL); // limit is exclusive
    add_row(odom(0, 0), 1, sib_pkg::ST_COLLECT);
    // extremes of the axes, then a timestamp that runs backwards
    w = imu(48'd1000, 0, 0, 0);
    for (int a = 0; a < 6; a++) w.ax[a] = 32'sh8000_0000;
    add_row(w, 1, sib_pkg::ST_COLLECT);
    w = imu(48'd0, 0, 0, 0);
    for (int a = 0; a < 6; a++) w.ax[a] = 32'sh7fff_ffff;
    add_row(w, 1, sib_pkg::ST_COLLECT);
    add_row(imu(48'hffff_ffff_ffff, 0, 0, 0), 1, sib_pkg::ST_TOO_FEW);
    // zero mean acceleration window, run through attempts
    for (int i = 0; i < 12; i++)
      add_row(imu(48'hffff_ffff_ffff, 3, 0, 0), 0, sib_pkg::ST_DONE);
    add_row(odom(0, 0), 1, sib_pkg::ST_COLLECT);    // still again: keep going
    add_row(imu(48'd7, 0, 0, 0), 1, sib_pkg::ST_COLLECT);
    for (int i = 0; i < n_rows; i++) begin
      send_word(rows[i].w);
      if (rows[i].typed && exp_mem[(exp_wr - 1) % EXP_DEPTH].st !== rows[i].st) begin
        errors++;
        if (errors <= 10) $display("row %0d: predictor gave %0d, table %0d", i,
                                   exp_mem[(exp_wr - 1) % EXP_DEPTH].st, rows[i].st);
      end
    end
    wait_idle();

    // random phases; a moving odometry word followed by a sample may clear
    // the window before the still window is sent
    for (p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 36 : (p < 4) ? 63 : 0;
      recv_idle = (p < 2) ? 63 : (p < 4) ? 36 : 0;
      reg_write(sib_pkg::REG_USE_STATIC, 64'($urandom_range(1)));
      reg_write(sib_pkg::REG_STILL_LIM, (p == 5) ? 64'hffff : 64'($urandom_range(1, 40)));
      reg_write(sib_pkg::REG_SETTLE, (p == 0) ? 64'd0 : 64'($urandom_range(50, 400)));
      reg_write(sib_pkg::REG_GRAVITY, (p == 1) ? 64'hffff_ffff : 64'(164584489));
      reg_write(sib_pkg::REG_MAX_GYRO,
                (p == 2) ? 64'd0 : 64'({16'd0, $urandom, $urandom} >> 16));
      reg_write(sib_pkg::REG_MAX_ACCEL,
                (p == 3) ? 64'd0 : 64'({16'd0, $urandom, $urandom} >> 8));
      bus_idle();
      if (p == 4) begin
        recv_hold = 1'b1;
        hold_cycles = 3000;
      end
      send_word(odom($urandom, $urandom));
      send_word(imu(48'({$urandom, $urandom}), $urandom, $urandom, 1000));
      still_window($urandom_range(8, 12), $urandom_range(1 << 12));
      recv_hold = 1'b0;
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
